/* sv/stpg_pkg.sv */
// ----------------------------------------------------------------------------
// stpg_pkg: shared types and constants of the scrolling text pixel generator
// Font table, command codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package stpg_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [0:0] REG_LENGTH = 1'd0;
    localparam logic [0:0] REG_DIR    = 1'd1;

    localparam int GLYPH_W       = 11;
    localparam int GLYPH_TOP     = 3;
    localparam int INK_FIRST     = 2;
    localparam int INK_ROWS      = 10;
    localparam int LONG_TEXT_MIN = 7;
    localparam logic [5:0] BLANK_GLYPH = 6'd36;

    // controller commands to the datapath
    typedef struct packed {
        logic load;    // capture the accepted word
        logic reduce;  // reduce offset by the current period
        logic step;    // apply tick, store offset
        logic wrap;    // form canvas coordinate
        logic lookup;  // register the pixel
    } t_dp_cmd;

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [5:0] g;
        g = BLANK_GLYPH;
        if (code >= 8'h61 && code <= 8'h7A) g = 6'(code - 8'h61);
        else if (code >= 8'h30 && code <= 8'h39) g = 6'(code - 8'h30 + 8'd26);
        return g;
    endfunction

    function automatic logic [10:0] font_row(input logic [5:0] g, input logic [3:0] r);
        logic [10:0] rows [0:9];
        case (g)
            6'd0:  rows = '{11'h020,11'h050,11'h050,11'h050,11'h088,11'h0F8,11'h088,11'h104,11'h104,11'h104};
            6'd1:  rows = '{11'h1F0,11'h108,11'h108,11'h108,11'h1F0,11'h108,11'h104,11'h104,11'h104,11'h1F8};
            6'd2:  rows = '{11'h0F8,11'h104,11'h100,11'h100,11'h100,11'h100,11'h100,11'h100,11'h104,11'h0F8};
            6'd3:  rows = '{11'h1F0,11'h108,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h108,11'h1F0};
            6'd4:  rows = '{11'h1FC,11'h100,11'h100,11'h100,11'h100,11'h1F8,11'h100,11'h100,11'h100,11'h1FC};
            6'd5:  rows = '{11'h1FC,11'h100,11'h100,11'h100,11'h100,11'h1F8,11'h100,11'h100,11'h100,11'h100};
            6'd6:  rows = '{11'h0F8,11'h104,11'h100,11'h100,11'h17C,11'h144,11'h104,11'h104,11'h104,11'h0F8};
            6'd7:  rows = '{11'h104,11'h104,11'h104,11'h104,11'h104,11'h1FC,11'h104,11'h104,11'h104,11'h104};
            6'd8:  rows = '{11'h1FC,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h1FC};
            6'd9:  rows = '{11'h004,11'h004,11'h004,11'h004,11'h004,11'h004,11'h004,11'h104,11'h104,11'h0F8};
            6'd10: rows = '{11'h104,11'h108,11'h110,11'h120,11'h140,11'h1C0,11'h120,11'h110,11'h108,11'h104};
            6'd11: rows = '{11'h100,11'h100,11'h100,11'h100,11'h100,11'h100,11'h100,11'h100,11'h100,11'h1FC};
            6'd12: rows = '{11'h104,11'h18C,11'h154,11'h124,11'h124,11'h124,11'h104,11'h104,11'h104,11'h104};
            6'd13: rows = '{11'h104,11'h184,11'h144,11'h144,11'h124,11'h124,11'h114,11'h114,11'h10C,11'h104};
            6'd14: rows = '{11'h0F8,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h0F8};
            6'd15: rows = '{11'h1F8,11'h104,11'h104,11'h104,11'h104,11'h1F8,11'h100,11'h100,11'h100,11'h100};
            6'd16: rows = '{11'h0F8,11'h104,11'h104,11'h104,11'h104,11'h104,11'h124,11'h114,11'h108,11'h0F4};
            6'd17: rows = '{11'h1F8,11'h104,11'h104,11'h104,11'h104,11'h1F8,11'h120,11'h110,11'h108,11'h104};
            6'd18: rows = '{11'h0F8,11'h104,11'h100,11'h100,11'h0F8,11'h004,11'h004,11'h004,11'h104,11'h0F8};
            6'd19: rows = '{11'h1FC,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020};
            6'd20: rows = '{11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h0F8};
            6'd21: rows = '{11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h104,11'h088,11'h050,11'h020};
            6'd22: rows = '{11'h104,11'h104,11'h104,11'h124,11'h124,11'h124,11'h124,11'h124,11'h124,11'h0D8};
            6'd23: rows = '{11'h104,11'h088,11'h088,11'h050,11'h050,11'h020,11'h050,11'h088,11'h088,11'h104};
            6'd24: rows = '{11'h104,11'h088,11'h050,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020,11'h020};
            6'd25: rows = '{11'h1FC,11'h004,11'h008,11'h010,11'h020,11'h020,11'h040,11'h080,11'h100,11'h1FC};
            6'd26: rows = '{11'h0F8,11'h184,11'h144,11'h144,11'h124,11'h124,11'h114,11'h114,11'h10C,11'h0F8};
            6'd27: rows = '{11'h020,11'h060,11'h0A0,11'h120,11'h020,11'h020,11'h020,11'h020,11'h020,11'h1FC};
            6'd28: rows = '{11'h0F8,11'h104,11'h004,11'h004,11'h008,11'h010,11'h020,11'h040,11'h080,11'h1FC};
            6'd29: rows = '{11'h0F8,11'h104,11'h004,11'h004,11'h0F8,11'h004,11'h004,11'h004,11'h104,11'h0F8};
            6'd30: rows = '{11'h020,11'h060,11'h0A0,11'h120,11'h120,11'h1FC,11'h020,11'h020,11'h020,11'h020};
            6'd31: rows = '{11'h1FC,11'h100,11'h100,11'h100,11'h1F8,11'h004,11'h004,11'h004,11'h104,11'h0F8};
            6'd32: rows = '{11'h0F8,11'h104,11'h100,11'h100,11'h1F8,11'h104,11'h104,11'h104,11'h104,11'h0F8};
            6'd33: rows = '{11'h1FC,11'h004,11'h008,11'h010,11'h020,11'h040,11'h040,11'h040,11'h040,11'h040};
            6'd34: rows = '{11'h0F8,11'h104,11'h104,11'h104,11'h0F8,11'h104,11'h104,11'h104,11'h104,11'h0F8};
            6'd35: rows = '{11'h0F8,11'h104,11'h104,11'h104,11'h0FC,11'h004,11'h004,11'h004,11'h104,11'h0F8};
            default: rows = '{default: 11'h000};
        endcase
        return (r < 4'd10) ? rows[r] : 11'h000;
    endfunction

endpackage

/* sv/stpg_ctrl.sv */
// ----------------------------------------------------------------------------
// stpg_ctrl: sequencing controller
// Accepts one word, steps the datapath through its phases, hands off a read's result.
// ----------------------------------------------------------------------------
module stpg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_cmd,
    input  logic               i_out_free,
    output logic               o_ready,
    output logic               o_result,
    output stpg_pkg::t_dp_cmd  o_dp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_WRAP   = 3'd2;
    localparam logic [2:0] S_LOOKUP = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_cmd;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_dp = '0;
        o_result = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_dp.load = 1'b1;
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_dp.reduce = 1'b1;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                o_dp.wrap = 1'b1;
                o_dp.step = (r_cmd == stpg_pkg::CMD_TICK);
                n_state = (r_cmd == stpg_pkg::CMD_READ) ? S_LOOKUP : S_IDLE;
            end
            S_LOOKUP: begin
                o_dp.lookup = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // hold until the output register is free
                if (i_out_free) begin
                    o_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_dp.load) r_cmd <= i_cmd;
    end

endmodule

/* sv/stpg_dp.sv */
// ----------------------------------------------------------------------------
// stpg_dp: datapath
// Text store, scroll offset, wrap arithmetic and font lookup.
// ----------------------------------------------------------------------------
module stpg_dp #(
    parameter int MAX_CHARS  = 20,
    parameter int VIEW_COLS  = 75,
    parameter int FRAME_ROWS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stpg_pkg::t_dp_cmd i_dp,
    input  logic [1:0]        i_cmd,
    input  logic [4:0]        i_char_pos,
    input  logic [7:0]        i_char_code,
    input  logic [4:0]        i_view_row,
    input  logic [6:0]        i_view_col,
    input  logic [4:0]        i_text_length,
    input  logic [1:0]        i_scroll_direction,
    output logic              o_pixel
);

    localparam int HMAX = MAX_CHARS * stpg_pkg::GLYPH_W;
    localparam int HMIN = stpg_pkg::LONG_TEXT_MIN * stpg_pkg::GLYPH_W;
    localparam int VMAX = (VIEW_COLS > FRAME_ROWS) ? VIEW_COLS : FRAME_ROWS;
    localparam int VMIN = (VIEW_COLS < FRAME_ROWS) ? VIEW_COLS : FRAME_ROWS;
    localparam int MAXP = (HMAX > VMAX) ? HMAX : VMAX;
    localparam int MINP = (HMIN < VMIN) ? HMIN : VMIN;
    localparam int PW   = $clog2(MAXP + VIEW_COLS);
    // compare-subtract steps that bring any stored offset below any period
    localparam int RS   = $clog2(MAXP / MINP + 1);
    localparam int RW   = PW + RS;
    localparam int IW   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    // floor(col / 11) as (col * 5958) >> 16, exact for col below 2^15
    localparam int RECIP    = 5958;
    localparam int RECIP_SH = 16;
    localparam int GW       = PW + 13;

    logic [7:0]    r_text [0:MAX_CHARS-1];
    logic [PW-1:0] r_off, r_offr, r_period;
    logic [4:0]    r_vrow;
    logic [6:0]    r_vcol;
    logic          r_inview;
    logic [5:0]    r_len;
    logic [6:0]    r_row;
    logic [PW-1:0] r_col;
    logic          r_pixel;

    logic [5:0]    len_eff;
    logic [PW-1:0] hper, period, sum, wsum, inc, dec;
    logic          horiz;

    assign horiz = (i_scroll_direction == stpg_pkg::DIR_LEFT) ||
                   (i_scroll_direction == stpg_pkg::DIR_RIGHT);
    assign len_eff = (32'(i_text_length) > MAX_CHARS) ? 6'(MAX_CHARS) : 6'(i_text_length);
    assign hper = (len_eff >= 6'(stpg_pkg::LONG_TEXT_MIN)) ?
                  PW'(len_eff) * PW'(stpg_pkg::GLYPH_W) : PW'(VIEW_COLS);
    assign period = horiz ? hper : PW'(FRAME_ROWS);

    // reduce offset by the period with shifted compare-subtract steps
    logic [RW-1:0] red_w;
    logic [PW-1:0] red;
    always_comb begin
        red_w = RW'(r_off);
        for (int k = RS - 1; k >= 0; k--) begin
            if (red_w >= (RW'(r_period) << k)) red_w = red_w - (RW'(r_period) << k);
        end
        red = red_w[PW-1:0];
    end

    assign sum  = horiz ? PW'(PW'(r_vcol) + r_offr) : PW'(PW'(r_vrow) + r_offr);
    assign wsum = (sum >= r_period) ? sum - r_period : sum;
    assign inc  = (r_offr + 1'b1 >= r_period) ? '0 : r_offr + 1'b1;
    assign dec  = (r_offr == '0) ? r_period - 1'b1 : r_offr - 1'b1;

    // column to glyph index and column within glyph
    logic [5:0]    gidx;
    logic [3:0]    gcol;
    logic [PW-1:0] colw;
    logic [GW-1:0] gprod;
    always_comb begin
        gprod = GW'(r_col) * GW'(RECIP);
        gidx  = 6'(gprod >> RECIP_SH);
        colw  = r_col - PW'(gidx) * PW'(stpg_pkg::GLYPH_W);
        gcol  = colw[3:0];
    end

    logic [7:0]  ch;
    logic [6:0]  gr;
    logic [10:0] frow;
    logic        bit_n;
    always_comb begin
        ch = (32'(gidx) < MAX_CHARS) ? r_text[gidx[IW-1:0]] : 8'd0;
        gr = r_row - 7'(stpg_pkg::GLYPH_TOP);
        frow = stpg_pkg::font_row(stpg_pkg::glyph_index(ch),
                                  4'(gr - 7'(stpg_pkg::INK_FIRST)));
        bit_n = 1'b0;
        if (r_inview && gidx < r_len && r_row >= 7'(stpg_pkg::GLYPH_TOP) &&
            gr >= 7'(stpg_pkg::INK_FIRST) &&
            gr < 7'(stpg_pkg::INK_FIRST + stpg_pkg::INK_ROWS))
            bit_n = frow[4'd10 - gcol];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (i_dp.step) begin
            r_off <= (i_scroll_direction == stpg_pkg::DIR_LEFT ||
                      i_scroll_direction == stpg_pkg::DIR_UP) ? inc : dec;
        end
        if (i_dp.load) begin
            r_vrow   <= i_view_row;
            r_vcol   <= i_view_col;
            r_inview <= (32'(i_view_row) < FRAME_ROWS) && (32'(i_view_col) < VIEW_COLS);
            r_period <= period;
            r_len    <= len_eff;
            if (i_cmd == stpg_pkg::CMD_WRITE && 32'(i_char_pos) < MAX_CHARS)
                r_text[i_char_pos[IW-1:0]] <= i_char_code;
        end
        if (i_dp.reduce) r_offr <= red;
        if (i_dp.wrap) begin
            if (horiz) begin
                r_row <= 7'(r_vrow);
                r_col <= wsum;
            end else begin
                r_row <= 7'(wsum);
                r_col <= PW'(r_vcol);
            end
        end
        if (i_dp.lookup) r_pixel <= bit_n;
    end

    assign o_pixel = r_pixel;

endmodule

/* sv/scrolling_text_pixel_generator.sv */
// ----------------------------------------------------------------------------
// scrolling_text_pixel_generator: LED marquee pixel source
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one word: write a character, advance
// the scroll one tick, or read one pixel of the view window. Only a read
// returns a word, on o_valid/i_ready with o_pixel_on.
// Write and tick pass through capture, shift-subtract offset reduction by the
// wrap period and wrap of the view coordinate; a read adds the font lookup, with
// its reciprocal glyph divide, and then the push into the output register. One
// word is in flight at a time, so o_ready stays low until a read is pushed; the
// next read can be accepted while the previous result still waits in the output
// register, and the block holds in its final step only if that register is
// still full and i_ready is low.
// Configuration (i_cfg_valid/o_cfg_ready, always ready) writes text_length
// (index 0) or scroll_direction (index 1); write only while idle.
// Reset clears offset, configuration registers, output valid and control; text is undefined until written.
// ----------------------------------------------------------------------------
module scrolling_text_pixel_generator #(
    parameter int MAX_CHARS  = 20,
    parameter int VIEW_COLS  = 75,
    parameter int FRAME_ROWS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_char_pos,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_view_row,
    input  logic [6:0] i_view_col,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_pixel_on,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    logic [4:0] r_text_length;
    logic [1:0] r_scroll_direction;
    logic       r_valid, r_pix;
    logic       out_free, push, pixel;
    stpg_pkg::t_dp_cmd dp;

    assign o_cfg_ready = 1'b1;
    assign out_free = !r_valid || i_ready;

    stpg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_cmd(i_cmd),
        .i_out_free(out_free), .o_ready(o_ready), .o_result(push), .o_dp(dp)
    );

    stpg_dp #(.MAX_CHARS(MAX_CHARS), .VIEW_COLS(VIEW_COLS), .FRAME_ROWS(FRAME_ROWS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_dp(dp), .i_cmd(i_cmd),
        .i_char_pos(i_char_pos), .i_char_code(i_char_code),
        .i_view_row(i_view_row), .i_view_col(i_view_col),
        .i_text_length(r_text_length), .i_scroll_direction(r_scroll_direction),
        .o_pixel(pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length      <= '0;
            r_scroll_direction <= '0;
            r_valid            <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == stpg_pkg::REG_LENGTH)
                r_text_length <= i_cfg_data;
            if (i_cfg_valid && i_cfg_index == stpg_pkg::REG_DIR)
                r_scroll_direction <= i_cfg_data[1:0];
            if (push) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        if (push) r_pix <= pixel;
    end

    assign o_valid    = r_valid;
    assign o_pixel_on = r_pix;

endmodule

/* sv/stpg_checker.sv */
// ----------------------------------------------------------------------------
// stpg_checker: port-level checks
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
module stpg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_pixel_on
);

    // result word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_on)) else $error("stall");

    // no word right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("reset");

    // an accepted word makes o_ready drop
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("busy");

    // o_valid rises only out of a busy state (o_ready low)
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready, 1)) else $error("latency");

endmodule

bind scrolling_text_pixel_generator stpg_checker u_stpg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_pixel_on(o_pixel_on)
);
